@@ hdl/pn3d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared types, widths and helpers of the 3D gradient noise block.
// ----------------------------------------------------------------------------
package pn3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 16;
  localparam int COORD_BITS = 24;
  localparam int CELL_BITS  = 8;
  localparam int NOISE_BITS = 16;
  localparam int HASH_BITS  = 4;
  localparam int CORNERS    = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef logic [FRAC_BITS-1:0] frac_t;

  // One evaluation request after hashing: the low hash bits of all eight
  // corners and the three fractions inside the cell.
  typedef struct packed {
    logic [CORNERS-1:0][HASH_BITS-1:0] hash;
    frac_t fx;
    frac_t fy;
    frac_t fz;
  } q_entry_t;

  function automatic logic [CELL_BITS-1:0] cell_of(logic [COORD_BITS-1:0] c);
    logic [COORD_BITS+CELL_BITS-1:0] e;
    e = (COORD_BITS+CELL_BITS)'(c);
    return e[FRAC_BITS +: CELL_BITS];
  endfunction

  function automatic frac_t frac_of(logic [COORD_BITS-1:0] c);
    return c[FRAC_BITS-1:0];
  endfunction

endpackage

@@ hdl/pn3d_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_in_if / pn3d_out_if
// Valid/ready channels for noise requests and noise results.
// ----------------------------------------------------------------------------
interface pn3d_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  table_index;
  logic [7:0]  table_value;
  logic [23:0] coord_x;
  logic [23:0] coord_y;
  logic [23:0] coord_z;

  modport source (output valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pn3d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

@@ hdl/pn3d_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pn3d_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [DATA_BITS-1:0] rdata_a,
  output logic [DATA_BITS-1:0] rdata_b
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hdl/pn3d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_front
// Accepts requests, applies table writes and hashes the eight cell corners.
// ----------------------------------------------------------------------------
module pn3d_front import pn3d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pn3d_in_if.sink  sample,
  output logic     push,
  output q_entry_t push_data,
  input  logic     q_full
);

  logic adv;

  logic                 vld0, vld1, vld2, vld3;
  cmd_t                 cmd0, cmd1, cmd2, cmd3;
  logic [7:0]           idx0, idx1, idx2, val0, val1, val2;
  logic [CELL_BITS-1:0] cx0, cy0, cz0, cy1, cz1, cz2;
  frac_t                fx0, fy0, fz0, fx1, fy1, fz1, fx2, fy2, fz2, fx3, fy3, fz3;

  logic [7:0] pa, pb;
  logic [7:0] a, b;
  logic [7:0] da0, db0, da1, db1;
  logic [7:0] aa, ba, ab, bb;
  logic [7:0] h0, h1, h2, h3, h4, h5, h6, h7;
  logic       we0, we1, we2;

  assign adv = !q_full;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (adv) begin
      vld0 <= sample.valid;
      vld1 <= vld0;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0 <= cmd_t'(sample.cmd);
      idx0 <= sample.table_index;
      val0 <= sample.table_value;
      cx0  <= cell_of(sample.coord_x);
      cy0  <= cell_of(sample.coord_y);
      cz0  <= cell_of(sample.coord_z);
      fx0  <= frac_of(sample.coord_x);
      fy0  <= frac_of(sample.coord_y);
      fz0  <= frac_of(sample.coord_z);
      cmd1 <= cmd0;
      idx1 <= idx0;
      val1 <= val0;
      cy1  <= cy0;
      cz1  <= cz0;
      fx1  <= fx0;
      fy1  <= fy0;
      fz1  <= fz0;
      cmd2 <= cmd1;
      idx2 <= idx1;
      val2 <= val1;
      cz2  <= cz1;
      fx2  <= fx1;
      fy2  <= fy1;
      fz2  <= fz1;
      cmd3 <= cmd2;
      fx3  <= fx2;
      fy3  <= fy2;
      fz3  <= fz2;
    end
  end

  // Each table copy is written when the write request passes the stage that
  // reads that copy, so every copy sees writes and lookups in request order.
  assign we0 = adv && vld0 && (cmd0 == CMD_WRITE);
  assign we1 = adv && vld1 && (cmd1 == CMD_WRITE);
  assign we2 = adv && vld2 && (cmd2 == CMD_WRITE);

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_x (
    .clk(clk), .we(we0), .waddr(idx0), .wdata(val0), .re(adv),
    .raddr_a(cx0), .raddr_b(cx0 + 8'd1), .rdata_a(pa), .rdata_b(pb)
  );

  assign a = pa + cy1;
  assign b = pb + cy1;

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_y0 (
    .clk(clk), .we(we1), .waddr(idx1), .wdata(val1), .re(adv),
    .raddr_a(a), .raddr_b(b), .rdata_a(da0), .rdata_b(db0)
  );

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_y1 (
    .clk(clk), .we(we1), .waddr(idx1), .wdata(val1), .re(adv),
    .raddr_a(a + 8'd1), .raddr_b(b + 8'd1), .rdata_a(da1), .rdata_b(db1)
  );

  assign aa = da0 + cz2;
  assign ba = db0 + cz2;
  assign ab = da1 + cz2;
  assign bb = db1 + cz2;

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_z0 (
    .clk(clk), .we(we2), .waddr(idx2), .wdata(val2), .re(adv),
    .raddr_a(aa), .raddr_b(ba), .rdata_a(h0), .rdata_b(h1)
  );

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_z1 (
    .clk(clk), .we(we2), .waddr(idx2), .wdata(val2), .re(adv),
    .raddr_a(ab), .raddr_b(bb), .rdata_a(h2), .rdata_b(h3)
  );

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_z2 (
    .clk(clk), .we(we2), .waddr(idx2), .wdata(val2), .re(adv),
    .raddr_a(aa + 8'd1), .raddr_b(ba + 8'd1), .rdata_a(h4), .rdata_b(h5)
  );

  pn3d_ram #(.ADDR_BITS(8), .DATA_BITS(8)) u_ram_z3 (
    .clk(clk), .we(we2), .waddr(idx2), .wdata(val2), .re(adv),
    .raddr_a(ab + 8'd1), .raddr_b(bb + 8'd1), .rdata_a(h6), .rdata_b(h7)
  );

  assign push = adv && vld3 && (cmd3 == CMD_EVAL);

  always_comb begin
    push_data.hash[0] = h0[HASH_BITS-1:0];
    push_data.hash[1] = h1[HASH_BITS-1:0];
    push_data.hash[2] = h2[HASH_BITS-1:0];
    push_data.hash[3] = h3[HASH_BITS-1:0];
    push_data.hash[4] = h4[HASH_BITS-1:0];
    push_data.hash[5] = h5[HASH_BITS-1:0];
    push_data.hash[6] = h6[HASH_BITS-1:0];
    push_data.hash[7] = h7[HASH_BITS-1:0];
    push_data.fx = fx3;
    push_data.fy = fy3;
    push_data.fz = fz3;
  end

endmodule

@@ hdl/pn3d_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_queue
// Short FIFO of hashed requests between the hashing and blending parts.
// ----------------------------------------------------------------------------
module pn3d_queue import pn3d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty,
  output logic     full
);

  q_entry_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

@@ hdl/pn3d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_back
// Fade curves, corner gradients, trilinear blend and output remapping.
// ----------------------------------------------------------------------------
module pn3d_back import pn3d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  head,
  input  logic      empty,
  output logic      pop,
  pn3d_out_if.source result
);

  localparam int VAL_BITS  = FRAC_BITS + 3;
  localparam int FADE_BITS = FRAC_BITS + 1;
  localparam int Q_BITS    = FRAC_BITS + 4;
  localparam int QX_BITS   = FRAC_BITS + 6;
  localparam int PROD_BITS = VAL_BITS + FADE_BITS + 2;
  localparam int SQ_BITS   = 2 * FRAC_BITS;
  localparam int FP_BITS   = FRAC_BITS + Q_BITS;
  localparam int SH        = OUT_BITS - FRAC_BITS - 1;
  localparam int SH_L      = (SH > 0) ? SH : 0;
  localparam int SH_R      = (SH < 0) ? -SH : 0;
  localparam int OW_BITS   = VAL_BITS + OUT_BITS + 1;
  localparam int STAGES    = 10;

  typedef logic signed [VAL_BITS-1:0]  val_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic [FADE_BITS-1:0]        fade_t;

  localparam val_t ONE_VAL = val_t'(1) <<< FRAC_BITS;
  localparam logic [OW_BITS-1:0] TOP = OW_BITS'((OW_BITS'(1) << OUT_BITS) - 1);

  function automatic val_t grad(logic [HASH_BITS-1:0] h, val_t dx, val_t dy, val_t dz);
    val_t u;
    val_t v;
    u = (h < 4'd8) ? dx : dy;
    v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic prod_t lerp_mul(fade_t t, val_t lo, val_t hi);
    logic signed [FADE_BITS:0] ts;
    logic signed [VAL_BITS:0]  d;
    prod_t p;
    ts = $signed({1'b0, t});
    d  = (VAL_BITS+1)'(hi) - (VAL_BITS+1)'(lo);
    p  = ts * d;
    return p;
  endfunction

  function automatic val_t lerp_add(val_t lo, prod_t p);
    return lo + val_t'(p >>> FRAC_BITS);
  endfunction

  logic              adv;
  logic [STAGES-1:0] vld;

  q_entry_t      e0;
  frac_t         f1 [3];
  frac_t         t2 [3];
  frac_t         t3 [3];
  logic [Q_BITS-1:0] q2 [3];
  fade_t         fd3 [3];
  val_t          g1 [CORNERS];
  val_t          g2 [CORNERS];
  val_t          g3 [CORNERS];
  prod_t         p4 [4];
  val_t          a4 [4];
  fade_t         v4, w4, v5, w5, w6, w7;
  val_t          l5 [4];
  prod_t         p6 [2];
  val_t          a6 [2];
  val_t          m7 [2];
  prod_t         p8;
  val_t          a8;
  val_t          r9;

  frac_t             fin [3];
  logic [SQ_BITS-1:0] sq [3];
  logic [SQ_BITS-1:0] cu [3];
  logic [QX_BITS-1:0] qraw [3];
  logic [FP_BITS-1:0] fp [3];
  val_t               dxyz [2][3];
  val_t               acc;
  logic [OW_BITS-1:0] ow;
  logic [OUT_BITS-1:0] sat;

  assign adv = !result.valid || result.ready;
  assign pop = adv && !empty;

  always_comb begin
    fin[0] = e0.fx;
    fin[1] = e0.fy;
    fin[2] = e0.fz;
    for (int i = 0; i < 3; i++) begin
      sq[i] = SQ_BITS'(fin[i]) * SQ_BITS'(fin[i]);
      cu[i] = SQ_BITS'(t2[i]) * SQ_BITS'(f1[i]);
      qraw[i] = QX_BITS'(6) * QX_BITS'(t2[i]) + (QX_BITS'(10) << FRAC_BITS)
              - QX_BITS'(15) * QX_BITS'(f1[i]);
      fp[i] = FP_BITS'(t3[i]) * FP_BITS'(q2[i]);
      dxyz[0][i] = val_t'({3'b000, fin[i]});
      dxyz[1][i] = val_t'({3'b000, fin[i]}) - ONE_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], !empty};
      result.valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0 <= head;
      for (int i = 0; i < 3; i++) begin
        f1[i] <= fin[i];
        t2[i] <= sq[i][SQ_BITS-1:FRAC_BITS];
        t3[i] <= cu[i][SQ_BITS-1:FRAC_BITS];
        // The fade polynomial stays positive on the unit interval; clamp anyway.
        q2[i] <= qraw[i][QX_BITS-1] ? '0 : qraw[i][Q_BITS-1:0];
        fd3[i] <= fp[i][FRAC_BITS +: FADE_BITS];
      end
      for (int k = 0; k < CORNERS; k++) begin
        g1[k] <= grad(e0.hash[k], dxyz[k%2][0], dxyz[(k/2)%2][1], dxyz[k/4][2]);
        g2[k] <= g1[k];
        g3[k] <= g2[k];
      end
      for (int k = 0; k < 4; k++) begin
        p4[k] <= lerp_mul(fd3[0], g3[2*k], g3[2*k+1]);
        a4[k] <= g3[2*k];
        l5[k] <= lerp_add(a4[k], p4[k]);
      end
      v4 <= fd3[1];
      w4 <= fd3[2];
      v5 <= v4;
      w5 <= w4;
      for (int k = 0; k < 2; k++) begin
        p6[k] <= lerp_mul(v5, l5[2*k], l5[2*k+1]);
        a6[k] <= l5[2*k];
        m7[k] <= lerp_add(a6[k], p6[k]);
      end
      w6 <= w5;
      w7 <= w6;
      p8 <= lerp_mul(w7, m7[0], m7[1]);
      a8 <= m7[0];
      r9 <= lerp_add(a8, p8);
      result.noise_value <= NOISE_BITS'(sat);
    end
  end

  // Remap r to (r + 1) / 2 and saturate to the output fraction width.
  always_comb begin
    acc = r9 + ONE_VAL;
    if (acc[VAL_BITS-1]) begin
      acc = '0;
    end
    ow = (OW_BITS'(acc) << SH_L) >> SH_R;
    sat = (ow > TOP) ? '1 : ow[OUT_BITS-1:0];
  end

endmodule

@@ hdl/perlin_noise_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise with a writable 256-entry permutation table.
// ----------------------------------------------------------------------------
// Channel | Dir | Carries
// --------+-----+--------------------------------------------------------
// sample  | in  | cmd, table_index, table_value, coord_x, coord_y, coord_z
// result  | out | noise_value, one per evaluate request
//
// One request per cycle is accepted while the queue is not full. A table write
// takes effect for all later requests and gives no result. An evaluate request
// passes the input register, the three table lookup levels, each a registered
// RAM read, the queue write, the read into the blend pipeline, then fade, blend
// and the output register before its result valid rises.
// Reset clears the pipelines and the queue, not the table. A stalled result
// first stops the blending pipeline; hashing stops once the queue fills.
// ----------------------------------------------------------------------------
module perlin_noise_3d import pn3d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pn3d_in_if.sink     sample,
  pn3d_out_if.source  result
);

  logic     push, pop, q_empty, q_full;
  q_entry_t push_data, head;

  pn3d_front u_front (
    .clk(clk), .rst(rst), .sample(sample),
    .push(push), .push_data(push_data), .q_full(q_full)
  );

  pn3d_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  pn3d_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(q_empty),
    .pop(pop), .result(result)
  );

endmodule

@@ hdl/pn3d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_checker
// Port-level checks of the noise block, bound to the top level.
// ----------------------------------------------------------------------------
module pn3d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] noise_value
);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("request not ready after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(noise_value))
    else $error("result changed while stalled");

endmodule

bind perlin_noise_3d pn3d_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .noise_value(result.noise_value)
);

@@ verif/tb_perlin_noise_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perlin_noise_3d
// Self-checking bench for the 3D gradient noise block. The permutation table
// is filled first, then directed and random requests are sent under random
// stalls on both channels. Each noise result is compared with a local model.
// ----------------------------------------------------------------------------
module tb_perlin_noise_3d;
  import pn3d_pkg::*;

  localparam int LATENCY = 16;

  logic clk;
  logic rst;

  pn3d_in_if  sample ();
  pn3d_out_if result ();

  perlin_noise_3d DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result)
  );

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] cz;
    bit          known;
    logic [15:0] noise;
  } request_t;

  logic [7:0]  perm_shadow [256];
  logic [15:0] noise_expected [$];
  request_t    directed [$];
  int          mismatches;
  int          noise_seen;
  int          writes_sent;
  bit          sending_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("perlin_noise_3d verification failed");
    $finish;
  end

  function automatic longint floor_fx(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
  endfunction

  function automatic longint fade_curve(longint f);
    longint t2;
    longint t3;
    longint q;
    t2 = (f * f) >> FRAC_BITS;
    t3 = (t2 * f) >> FRAC_BITS;
    q  = 6 * t2 - 15 * f + 10 * (64'sd1 << FRAC_BITS);
    if (q < 0) q = 0;
    return (t3 * q) >> FRAC_BITS;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + floor_fx(t * (b - a));
  endfunction

  function automatic longint gradient(logic [7:0] hash, longint dx, longint dy, longint dz);
    logic [3:0] h;
    longint     u;
    longint     v;
    h = hash[3:0];
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] lookup(int i);
    return perm_shadow[i & 255];
  endfunction

  function automatic logic [15:0] noise_at(logic [23:0] cx, logic [23:0] cy,
                                            logic [23:0] cz);
    longint one;
    longint x, y, z, x1, y1, z1, u, v, w, r, acc;
    int     ix, iy, iz, a, aa, ab, b, ba, bb;
    longint lo, hi;
    one = 64'sd1 << FRAC_BITS;
    ix = cx[23:16]; iy = cy[23:16]; iz = cz[23:16];
    x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
    x1 = x - one; y1 = y - one; z1 = z - one;
    u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
    a  = lookup(ix) + iy;
    aa = lookup(a) + iz;
    ab = lookup(a + 1) + iz;
    b  = lookup(ix + 1) + iy;
    ba = lookup(b) + iz;
    bb = lookup(b + 1) + iz;
    lo = blend(v, blend(u, gradient(lookup(aa), x, y, z), gradient(lookup(ba), x1, y, z)),
                  blend(u, gradient(lookup(ab), x, y1, z), gradient(lookup(bb), x1, y1, z)));
    hi = blend(v, blend(u, gradient(lookup(aa + 1), x, y, z1),
                           gradient(lookup(ba + 1), x1, y, z1)),
                  blend(u, gradient(lookup(ab + 1), x, y1, z1),
                           gradient(lookup(bb + 1), x1, y1, z1)));
    r = blend(w, lo, hi);
    acc = r + one;
    if (acc < 0) acc = 0;
    // OUT_BITS equals FRAC_BITS, so the scale to [0,1] is one right shift.
    acc = acc >> 1;
    if (acc > 65535) acc = 65535;
    return acc[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Draws a gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send(request_t rq);
    logic [15:0] want;
    repeat (gap_len()) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid       <= 1'b1;
    sample.cmd         <= rq.cmd;
    sample.table_index <= rq.idx;
    sample.table_value <= rq.val;
    sample.coord_x     <= rq.cx;
    sample.coord_y     <= rq.cy;
    sample.coord_z     <= rq.cz;
    do @(posedge clk); while (!sample.ready);
    if (rq.cmd == CMD_WRITE) begin
      perm_shadow[rq.idx] = rq.val;
      writes_sent++;
    end else begin
      want = rq.known ? rq.noise : noise_at(rq.cx, rq.cy, rq.cz);
      noise_expected = {noise_expected, want};
    end
  endtask

  task automatic add_row(request_t rq);
    directed = {directed, rq};
  endtask

  function automatic request_t eval_req(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                                        bit known, logic [15:0] n);
    request_t rq;
    rq.cmd = CMD_EVAL; rq.idx = 8'($urandom); rq.val = 8'($urandom);
    rq.cx = x; rq.cy = y; rq.cz = z; rq.known = known; rq.noise = n;
    return rq;
  endfunction

  function automatic request_t write_req(logic [7:0] i, logic [7:0] v);
    request_t rq;
    rq.cmd = CMD_WRITE; rq.idx = i; rq.val = v;
    rq.cx = 24'($urandom); rq.cy = 24'($urandom); rq.cz = 24'($urandom);
    rq.known = 1'b0; rq.noise = '0;
    return rq;
  endfunction

  // Result side: random back-pressure, checks each result in order.
  initial begin
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      result.ready <= (gap_len() == 0);
      @(posedge clk);
      if (result.valid && result.ready) begin
        noise_seen++;
        if (noise_expected.size() == 0) begin
          report_mismatch("unexpected noise_value", result.noise_value, 'x);
        end else begin
          logic [15:0] want;
          want = noise_expected.pop_front();
          if (result.noise_value !== want) report_mismatch("noise_value", result.noise_value, want);
        end
      end
    end
  end

  initial begin
    request_t rq;
    int       k;
    int       p;
    mismatches = 0; noise_seen = 0; writes_sent = 0;
    rst = 1'b1;
    sample.valid = 1'b0; sample.cmd = CMD_WRITE; sample.table_index = '0;
    sample.table_value = '0; sample.coord_x = '0; sample.coord_y = '0; sample.coord_z = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry is written before any lookup; all zeros first, so the
    // directed corner points have values that can be read off by hand.
    for (k = 0; k < 256; k++) send(write_req(k[7:0], 8'h00));

    // With an all-zero table every hash is 0, giving gradient x + y.
    // At the cell origin all offsets are zero, so the result is exactly one half.
    add_row(eval_req(24'h000000, 24'h000000, 24'h000000, 1'b1, 16'h8000));
    add_row(eval_req(24'hFF0000, 24'hFF0000, 24'hFF0000, 1'b1, 16'h8000));
    add_row(eval_req(24'h120000, 24'h340000, 24'h560000, 1'b1, 16'h8000));
    add_row(eval_req(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0));
    add_row(eval_req(24'h00FFFF, 24'h000000, 24'hFFFFFF, 1'b0, '0));
    add_row(eval_req(24'h008000, 24'h008000, 24'h008000, 1'b0, '0));
    // Hash 0 everywhere with x and y just below the next lattice line.
    add_row(eval_req(24'h00FFFF, 24'h00FFFF, 24'h000000, 1'b0, '0));
    add_row(write_req(8'h00, 8'hFF));
    add_row(write_req(8'hFF, 8'h01));
    // Hash 3 gives -x - y on the corners that land on these entries.
    for (k = 1; k < 8; k++) add_row(write_req(k[7:0], 8'h03));
    add_row(eval_req(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, '0));
    add_row(eval_req(24'h01C000, 24'h024000, 24'h03A000, 1'b0, '0));
    add_row(eval_req(24'hFE8001, 24'h7F7FFF, 24'h80AAAA, 1'b0, '0));
    foreach (directed[i]) send(directed[i]);

    // Random phase: mostly evaluations, with table rewrites mixed in that
    // keep every entry defined.
    for (k = 0; k < 277; k++) begin
      p = $urandom_range(0, 99);
      if (p < 35) begin
        send(write_req(8'($urandom), 8'($urandom)));
      end else if (p < 42) begin
        send(eval_req({8'($urandom), 16'($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000)},
                      {8'($urandom), 16'($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom))},
                      24'($urandom), 1'b0, '0));
      end else begin
        send(eval_req(24'($urandom), 24'($urandom), 24'($urandom), 1'b0, '0));
      end
    end
    sample.valid <= 1'b0;

    k = 0;
    while (noise_expected.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (4 * LATENCY) @(posedge clk);
    $display("Run covered %0d table writes and %0d noise results under random stalls.",
             writes_sent, noise_seen);
    if (mismatches == 0 && noise_expected.size() == 0) begin
      $display("perlin_noise_3d verification clean");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d", mismatches,
               noise_expected.size());
      $display("perlin_noise_3d verification failed");
    end
    $finish;
  end

endmodule
